[src/fcbs_pkg.sv]
// shared types and constants for the frustum cull box/sphere unit
package fcbs_pkg;

    localparam int COORD_W     = 16;
    localparam int RADIUS_W    = 16;
    localparam int NCOMP_W     = 10;
    localparam int OFFS_W      = 34;
    localparam int PROD_W      = NCOMP_W + COORD_W;
    localparam int DIST_W      = 36;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COUNT_W     = 3;
    localparam int RESULT_W    = 2;

    // configuration register map
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_COUNT = 3'd0;
    localparam int                     CFG_PLANE_BASE  = 1;
    localparam int                     CFG_PLANE_REGS  = 5;

    // func codes
    localparam logic FUNC_BOX    = 1'b0;
    localparam logic FUNC_SPHERE = 1'b1;

    // cull result codes
    localparam logic [RESULT_W-1:0] RESULT_INSIDE  = 2'd0;
    localparam logic [RESULT_W-1:0] RESULT_PARTIAL = 2'd1;
    localparam logic [RESULT_W-1:0] RESULT_OUTSIDE = 2'd2;

    typedef struct packed {
        logic signed [OFFS_W-1:0]  d;
        logic signed [NCOMP_W-1:0] nz;
        logic signed [NCOMP_W-1:0] ny;
        logic signed [NCOMP_W-1:0] nx;
    } plane_t;

    typedef struct packed {
        logic outside;
        logic partial;
    } verdict_t;

endpackage

[src/fcbs_plane_regs.sv]
// plane store and plane count configuration registers
module fcbs_plane_regs #(
    parameter int MAX_PLANES = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    input  logic [fcbs_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [fcbs_pkg::CFG_DATA_W-1:0]        cfg_data,
    output fcbs_pkg::plane_t [MAX_PLANES-1:0]      planes,
    output logic [MAX_PLANES-1:0]                  active
);

    logic [fcbs_pkg::COUNT_W-1:0] count_reg;
    logic [fcbs_pkg::COUNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (cfg_valid && cfg_index == fcbs_pkg::CFG_PLANE_COUNT)
        begin
            count_next = cfg_data[fcbs_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < MAX_PLANES; i++)
    begin : g_plane
        fcbs_pkg::plane_t plane_reg;
        fcbs_pkg::plane_t plane_next;
        logic             wr_en;

        // entries beyond the register map have no write path and stay zero
        assign wr_en = cfg_valid && (i < fcbs_pkg::CFG_PLANE_REGS)
                       && (cfg_index == fcbs_pkg::CFG_INDEX_W'(fcbs_pkg::CFG_PLANE_BASE + i));

        always_comb
        begin
            plane_next = plane_reg;
            if (wr_en)
            begin
                plane_next = cfg_data;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg <= '0;
            end
            else
            begin
                plane_reg <= plane_next;
            end
        end

        assign planes[i] = plane_reg;
        // counts above the store saturate since higher planes do not exist
        assign active[i] = count_reg > fcbs_pkg::COUNT_W'(i);
    end

endmodule

[src/fcbs_plane_test.sv]
// distance test of one shape against one plane
module fcbs_plane_test (
    input  fcbs_pkg::plane_t                        plane,
    input  logic                                    func,
    input  logic signed [fcbs_pkg::COORD_W-1:0]     min_x,
    input  logic signed [fcbs_pkg::COORD_W-1:0]     min_y,
    input  logic signed [fcbs_pkg::COORD_W-1:0]     min_z,
    input  logic signed [fcbs_pkg::COORD_W-1:0]     max_x,
    input  logic signed [fcbs_pkg::COORD_W-1:0]     max_y,
    input  logic signed [fcbs_pkg::COORD_W-1:0]     max_z,
    input  logic signed [fcbs_pkg::DIST_W-1:0]      rad_scaled,
    output fcbs_pkg::verdict_t                      verdict
);

    localparam int CW = fcbs_pkg::COORD_W;
    localparam int PW = fcbs_pkg::PROD_W;
    localparam int DW = fcbs_pkg::DIST_W;

    logic                 sphere;
    logic signed [CW-1:0] px, py, pz, qx, qy, qz;
    logic signed [PW-1:0] ppx, ppy, ppz, pqx, pqy, pqz;
    logic signed [DW-1:0] dist_p, dist_n, dist_s;

    assign sphere = (func == fcbs_pkg::FUNC_SPHERE);

    // positive vertex, or the sphere centre
    assign px = (sphere || plane.nx < 0) ? min_x : max_x;
    assign py = (sphere || plane.ny < 0) ? min_y : max_y;
    assign pz = (sphere || plane.nz < 0) ? min_z : max_z;

    // negative vertex
    assign qx = (plane.nx > 0) ? min_x : max_x;
    assign qy = (plane.ny > 0) ? min_y : max_y;
    assign qz = (plane.nz > 0) ? min_z : max_z;

    assign ppx = PW'(plane.nx) * PW'(px);
    assign ppy = PW'(plane.ny) * PW'(py);
    assign ppz = PW'(plane.nz) * PW'(pz);
    assign pqx = PW'(plane.nx) * PW'(qx);
    assign pqy = PW'(plane.ny) * PW'(qy);
    assign pqz = PW'(plane.nz) * PW'(qz);

    assign dist_p = DW'(ppx) + DW'(ppy) + DW'(ppz) + DW'(plane.d);
    assign dist_n = DW'(pqx) + DW'(pqy) + DW'(pqz) + DW'(plane.d);
    assign dist_s = dist_p + rad_scaled;

    always_comb
    begin
        if (sphere)
        begin
            verdict.outside = dist_s < 0;
            verdict.partial = 1'b0;
        end
        else
        begin
            verdict.outside = dist_p <= 0;
            verdict.partial = dist_n <= 0;
        end
    end

endmodule

[src/frustum_cull_box_sphere_unit.sv]
// top level: input register, per-plane tests and result register
// an accepted input transaction passes the input register and then the result register before out_valid rises
// one transaction per cycle unless the output stalls, all planes tested in parallel
// an input transaction is taken while a result waits if the input register is empty,
// the input register and the output register hold one transaction each
// reset clears valid flags, plane count and all plane registers to zero
module frustum_cull_box_sphere_unit #(
    parameter int MAX_PLANES       = 5,
    parameter int NORMAL_FRAC_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   func,
    input  logic signed [fcbs_pkg::COORD_W-1:0]    min_x,
    input  logic signed [fcbs_pkg::COORD_W-1:0]    min_y,
    input  logic signed [fcbs_pkg::COORD_W-1:0]    min_z,
    input  logic signed [fcbs_pkg::COORD_W-1:0]    max_x,
    input  logic signed [fcbs_pkg::COORD_W-1:0]    max_y,
    input  logic signed [fcbs_pkg::COORD_W-1:0]    max_z,
    input  logic [fcbs_pkg::RADIUS_W-1:0]          radius,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [fcbs_pkg::RESULT_W-1:0]          cull_result,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fcbs_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [fcbs_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int CW = fcbs_pkg::COORD_W;
    localparam int RW = fcbs_pkg::RADIUS_W;
    localparam int DW = fcbs_pkg::DIST_W;

    fcbs_pkg::plane_t [MAX_PLANES-1:0] planes;
    logic [MAX_PLANES-1:0]             active;
    fcbs_pkg::verdict_t                verdicts [MAX_PLANES];

    logic                 s1_valid_reg, s1_valid_next;
    logic                 func_reg;
    logic signed [CW-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [CW-1:0] max_x_reg, max_y_reg, max_z_reg;
    logic [RW-1:0]        radius_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [fcbs_pkg::RESULT_W-1:0] result_reg, result_next;

    logic                 in_take;
    logic                 out_free;
    logic                 s1_move;
    logic signed [DW-1:0] rad_scaled;
    logic                 any_outside;
    logic                 any_partial;

    assign cfg_ready = 1'b1;

    fcbs_plane_regs #(
        .MAX_PLANES (MAX_PLANES)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .planes    (planes),
        .active    (active)
    );

    // handshake and stage advance
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign rad_scaled = $signed(DW'(radius_reg) << NORMAL_FRAC_BITS);

    for (genvar i = 0; i < MAX_PLANES; i++)
    begin : g_test
        fcbs_plane_test u_test (
            .plane      (planes[i]),
            .func       (func_reg),
            .min_x      (min_x_reg),
            .min_y      (min_y_reg),
            .min_z      (min_z_reg),
            .max_x      (max_x_reg),
            .max_y      (max_y_reg),
            .max_z      (max_z_reg),
            .rad_scaled (rad_scaled),
            .verdict    (verdicts[i])
        );
    end

    // outside on any active plane wins over partial
    always_comb
    begin
        any_outside = 1'b0;
        any_partial = 1'b0;
        for (int i = 0; i < MAX_PLANES; i++)
        begin
            any_outside = any_outside | (active[i] & verdicts[i].outside);
            any_partial = any_partial | (active[i] & verdicts[i].partial);
        end
    end

    always_comb
    begin
        if (any_outside)
        begin
            result_next = fcbs_pkg::RESULT_OUTSIDE;
        end
        else if (any_partial)
        begin
            result_next = fcbs_pkg::RESULT_PARTIAL;
        end
        else
        begin
            result_next = fcbs_pkg::RESULT_INSIDE;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg   <= func;
            min_x_reg  <= min_x;
            min_y_reg  <= min_y;
            min_z_reg  <= min_z;
            max_x_reg  <= max_x;
            max_y_reg  <= max_y;
            max_z_reg  <= max_z;
            radius_reg <= radius;
        end
        if (s1_move)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cull_result = result_reg;

endmodule
